// ===== rtl/ksbc_pkg.sv =====
// ----------------------------------------------------------------------------
// ksbc_pkg: shared types and codes of the keyed s-box byte cipher
// Mode codes, datapath operation codes and the command and status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ksbc_pkg;

	localparam int BYTE_W      = 8;
	localparam int KEY_W       = 64;
	localparam int TABLE_DEPTH = 256;
	localparam int OP_W        = 4;

	// item modes carried on s_tuser
	localparam logic [1:0] MODE_SCHED = 2'd0;
	localparam logic [1:0] MODE_ENC   = 2'd1;
	localparam logic [1:0] MODE_DEC   = 2'd2;

	// datapath operations
	localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
	localparam logic [OP_W-1:0] OP_FILL    = 4'd1;
	localparam logic [OP_W-1:0] OP_RD_I    = 4'd2;
	localparam logic [OP_W-1:0] OP_RD_J    = 4'd3;
	localparam logic [OP_W-1:0] OP_WR_I    = 4'd4;
	localparam logic [OP_W-1:0] OP_WR_J    = 4'd5;
	localparam logic [OP_W-1:0] OP_INV_RD  = 4'd6;
	localparam logic [OP_W-1:0] OP_INV_WR  = 4'd7;
	localparam logic [OP_W-1:0] OP_CIPH_RD = 4'd8;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		byte_t           idx;
		logic            take;
		logic            load;
		logic            finish;
	} ksbc_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       ready;
	} ksbc_stat_t;

endpackage

// ===== rtl/ksbc_ram.sv =====
// ----------------------------------------------------------------------------
// ksbc_ram: generic single-port-write, single-port-read ram
// One write and one read per cycle, read data registered and held while
// no read is enabled.
// ----------------------------------------------------------------------------
module ksbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/ksbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ksbc_ctrl: sequencer of the keyed s-box byte cipher
// Accepts one word at a time, steps the key schedule over the tables and
// hands finished results to the output register.
// ----------------------------------------------------------------------------
module ksbc_ctrl import ksbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic       m_tready,
	output logic       m_tvalid,
	input  ksbc_stat_t stat,
	output ksbc_cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DEC    = 4'd1;
	localparam logic [3:0] ST_FILL   = 4'd2;
	localparam logic [3:0] ST_RD_I   = 4'd3;
	localparam logic [3:0] ST_RD_J   = 4'd4;
	localparam logic [3:0] ST_WR_I   = 4'd5;
	localparam logic [3:0] ST_WR_J   = 4'd6;
	localparam logic [3:0] ST_INV_RD = 4'd7;
	localparam logic [3:0] ST_INV_WR = 4'd8;
	localparam logic [3:0] ST_CIPH   = 4'd9;
	localparam logic [3:0] ST_FIN    = 4'd10;

	localparam byte_t LAST_IDX = byte_t'(TABLE_DEPTH - 1);

	logic [3:0] state_q, state_d;
	byte_t      cnt_q, cnt_d;
	logic       m_tvalid_q, m_tvalid_d;
	logic       last;
	logic       out_free;

	assign last     = (cnt_q == LAST_IDX);
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	// next state and command
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		cmd.op     = OP_NONE;
		cmd.idx    = cnt_q;
		cmd.take   = 1'b0;
		cmd.load   = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_d  = ST_DEC;
				end
			end
			ST_DEC: begin
				cnt_d = '0;
				case (stat.mode)
					MODE_SCHED: state_d = ST_FILL;
					MODE_ENC,
					MODE_DEC:   state_d = stat.ready ? ST_CIPH : ST_FIN;
					default:    state_d = ST_FIN;
				endcase
			end
			ST_FILL: begin
				cmd.op = OP_FILL;
				cnt_d  = cnt_q + 1'b1;
				if (last) begin
					state_d = ST_RD_I;
				end
			end
			ST_RD_I: begin
				cmd.op  = OP_RD_I;
				state_d = ST_RD_J;
			end
			ST_RD_J: begin
				cmd.op  = OP_RD_J;
				state_d = ST_WR_I;
			end
			ST_WR_I: begin
				cmd.op  = OP_WR_I;
				state_d = ST_WR_J;
			end
			ST_WR_J: begin
				cmd.op  = OP_WR_J;
				cnt_d   = cnt_q + 1'b1;
				state_d = last ? ST_INV_RD : ST_RD_I;
			end
			ST_INV_RD: begin
				cmd.op  = OP_INV_RD;
				state_d = ST_INV_WR;
			end
			ST_INV_WR: begin
				cmd.op  = OP_INV_WR;
				cnt_d   = cnt_q + 1'b1;
				if (last) begin
					cmd.finish = 1'b1;
					state_d    = ST_FIN;
				end else begin
					state_d = ST_INV_RD;
				end
			end
			ST_CIPH: begin
				cmd.op  = OP_CIPH_RD;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output valid flag
	always_comb begin
		m_tvalid_d = m_tvalid_q;
		if (cmd.load) begin
			m_tvalid_d = 1'b1;
		end else if (m_tready) begin
			m_tvalid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

endmodule

// ===== rtl/ksbc_dp.sv =====
// ----------------------------------------------------------------------------
// ksbc_dp: datapath of the keyed s-box byte cipher
// Key register, forward and inverse tables, schedule index j, subkeys and
// the output register, all driven by the controller's command.
// ----------------------------------------------------------------------------
module ksbc_dp import ksbc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [KEY_W-1:0] cfg_wr_data,
	input  byte_t            s_tdata,
	input  logic [1:0]       s_tuser,
	input  ksbc_cmd_t        cmd,
	output ksbc_stat_t       stat,
	output byte_t            m_tdata,
	output logic             m_tuser
);

	logic [KEY_W-1:0] key_q;
	logic [1:0]       mode_q;
	logic             ready_q;
	byte_t            add_q, xor_q;
	byte_t            din_q, j_q, si_q;
	byte_t            out_data_q;
	logic             out_status_q;

	logic  fwd_we, fwd_re, inv_we, inv_re;
	byte_t fwd_waddr, fwd_wdata, fwd_raddr, fwd_rdata;
	byte_t inv_waddr, inv_wdata, inv_raddr, inv_rdata;
	byte_t key_byte, j_next;
	byte_t res_data;
	logic  res_status;

	// key bytes taken cyclically, little-endian
	assign key_byte = key_q[{cmd.idx[2:0], 3'b000} +: BYTE_W];
	assign j_next   = j_q + fwd_rdata + key_byte;

	ksbc_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_DEPTH)) u_fwd_ram (
		.clk   (clk),
		.we    (fwd_we),
		.waddr (fwd_waddr),
		.wdata (fwd_wdata),
		.re    (fwd_re),
		.raddr (fwd_raddr),
		.rdata (fwd_rdata)
	);

	ksbc_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_DEPTH)) u_inv_ram (
		.clk   (clk),
		.we    (inv_we),
		.waddr (inv_waddr),
		.wdata (inv_wdata),
		.re    (inv_re),
		.raddr (inv_raddr),
		.rdata (inv_rdata)
	);

	// table port control
	always_comb begin
		fwd_we    = 1'b0;
		fwd_waddr = cmd.idx;
		fwd_wdata = cmd.idx;
		fwd_re    = 1'b0;
		fwd_raddr = cmd.idx;
		inv_we    = 1'b0;
		inv_waddr = fwd_rdata;
		inv_wdata = cmd.idx;
		inv_re    = 1'b0;
		inv_raddr = din_q ^ xor_q;
		case (cmd.op)
			OP_FILL: begin
				fwd_we = 1'b1;
			end
			OP_RD_I,
			OP_INV_RD: begin
				fwd_re = 1'b1;
			end
			OP_RD_J: begin
				fwd_re    = 1'b1;
				fwd_raddr = j_next;
			end
			OP_WR_I: begin
				fwd_we    = 1'b1;
				fwd_wdata = fwd_rdata;
			end
			OP_WR_J: begin
				fwd_we    = 1'b1;
				fwd_waddr = j_q;
				fwd_wdata = si_q;
			end
			OP_INV_WR: begin
				inv_we = 1'b1;
			end
			OP_CIPH_RD: begin
				if (mode_q == MODE_ENC) begin
					fwd_re    = 1'b1;
					fwd_raddr = din_q + add_q;
				end else begin
					inv_re = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// result of the current word
	always_comb begin
		res_data   = '0;
		res_status = 1'b0;
		case (mode_q)
			MODE_ENC: begin
				if (!ready_q) begin
					res_status = 1'b1;
				end else begin
					res_data = fwd_rdata ^ xor_q;
				end
			end
			MODE_DEC: begin
				if (!ready_q) begin
					res_status = 1'b1;
				end else begin
					res_data = inv_rdata - add_q;
				end
			end
			default: begin
			end
		endcase
	end

	// key, subkeys and schedule flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			mode_q  <= MODE_SCHED;
			ready_q <= 1'b0;
			add_q   <= '0;
			xor_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				key_q <= cfg_wr_data;
			end
			if (cmd.take) begin
				mode_q <= s_tuser;
			end
			if (cmd.finish) begin
				add_q   <= key_q[BYTE_W-1:0];
				xor_q   <= key_q[2*BYTE_W-1:BYTE_W];
				ready_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			din_q <= s_tdata;
		end
		if (cmd.op == OP_FILL) begin
			j_q <= '0;
		end else if (cmd.op == OP_RD_J) begin
			j_q  <= j_next;
			si_q <= fwd_rdata;
		end
		if (cmd.load) begin
			out_data_q   <= res_data;
			out_status_q <= res_status;
		end
	end

	assign stat.mode  = mode_q;
	assign stat.ready = ready_q;
	assign m_tdata    = out_data_q;
	assign m_tuser    = out_status_q;

endmodule

// ===== rtl/keyed_sbox_byte_cipher_core.sv =====
// ----------------------------------------------------------------------------
// keyed_sbox_byte_cipher_core: keyed s-box byte cipher, top level
// Byte encrypt and decrypt through a key-scheduled 256-entry permutation.
// ----------------------------------------------------------------------------
// usage:
//   load the 64-bit key through cfg_wr_en / cfg_wr_data while the core is idle,
//   then send a schedule word (s_tuser = 0) before any encrypt (1) or
//   decrypt (2) word. every input word gives exactly one output word.
//   a cipher word before the first schedule returns data 0 with status 1.
// sequence:
//   one word is worked on at a time; s_tready is high only between words.
//   an encrypt or decrypt word goes from accept through decode, one table read
//   and a finish state that loads the output register and raises m_tvalid;
//   without a table read (before the first schedule, unused mode) it skips the read.
//   a schedule word fills the forward table with the identity, swaps per entry
//   by reading i, reading j, writing i and writing j (the single read and write
//   port of the forward table), then reads it again to build the inverse table.
// reset and stalls:
//   arst_n clears the key, the subkeys and the schedule flag; table contents
//   are not cleared and no clearing pass runs. a result waits in the output
//   register while m_tready is low; the core then holds its next result
//   until the register is free.
// ----------------------------------------------------------------------------
module keyed_sbox_byte_cipher_core import ksbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [63:0] cfg_wr_data,   // cipher_key
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,       // [7:0] data_in
	input  logic [1:0]  s_tuser,       // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,       // [7:0] data_out
	output logic [0:0]  m_tuser        // [0] status
);

	ksbc_cmd_t  cmd;
	ksbc_stat_t stat;

	ksbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.stat     (stat),
		.cmd      (cmd)
	);

	ksbc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.cmd         (cmd),
		.stat        (stat),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser[0])
	);

	// an unscheduled status word always carries zero data
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 8'd0)
		else $error("status word with nonzero data");

	// a result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!m_tvalid || m_tready))
		else $error("output register overwritten");

	// the end of a schedule leaves the tables marked ready
	a_ready_after_sched: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> stat.ready)
		else $error("schedule finished without ready flag");

	// no word accepted while the datapath is busy on the tables
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op != OP_NONE |-> !s_tready)
		else $error("input accepted during table work");

endmodule
